// ===== rtl/kalman_filter_const_accel_core_assert.svh =====
// assertion macros for the kalman filter rtl, used by the sequencer
// expects clk and rst_n in the scope of each use
`ifndef KALMAN_FILTER_CONST_ACCEL_CORE_ASSERT_SVH
`define KALMAN_FILTER_CONST_ACCEL_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define KFCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define KFCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KFCA_ASSERT_NOW(lbl, ante, cons, msg)
`define KFCA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/kfca_pkg.sv =====
// types, constants and the operation program of the kalman filter core
// no dependencies
`timescale 1ns / 1ps
package kfca_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int EXT_BITS  = 2 * WORD_BITS + 2;
  localparam int DVD_BITS  = WORD_BITS + FRAC_BITS;
  localparam int NREG      = 6;
  localparam int REG_W     = 31;
  localparam int RF_DEPTH  = 32;
  localparam int RF_AW     = 5;
  localparam int NOPS      = 82;
  localparam int PC_BITS   = 7;

  // register indexes
  localparam logic [2:0] REG_TIME_STEP = 3'd0;
  localparam logic [2:0] REG_PROC_NOISE = 3'd1;
  localparam logic [2:0] REG_MEAS_NOISE = 3'd2;
  localparam logic [2:0] REG_INIT_POS = 3'd3;
  localparam logic [2:0] REG_INIT_VEL = 3'd4;
  localparam logic [2:0] REG_INIT_ACC = 3'd5;

  localparam logic [REG_W-1:0] RST_TIME_STEP = 31'd6554;
  localparam logic [REG_W-1:0] RST_PROC_NOISE = 31'd1966;
  localparam logic [REG_W-1:0] RST_MEAS_NOISE = 31'd6554;
  localparam logic [REG_W-1:0] RST_INIT_POS = 31'd229376;
  localparam logic [REG_W-1:0] RST_INIT_VEL = 31'd229376;
  localparam logic [REG_W-1:0] RST_INIT_ACC = 31'd983040;

  typedef logic [NREG-1:0][REG_W-1:0] cfg_arr_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] measured_accel;
    logic                        restart;
  } in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] est_position;
    logic signed [WORD_BITS-1:0] est_velocity;
    logic signed [WORD_BITS-1:0] est_accel;
    logic                        saturated;
  } out_t;

  // operation codes
  localparam logic [3:0] OP_CLR  = 4'd0;
  localparam logic [3:0] OP_LDC  = 4'd1;
  localparam logic [3:0] OP_LDZ  = 4'd2;
  localparam logic [3:0] OP_MUL  = 4'd3;
  localparam logic [3:0] OP_MULH = 4'd4;
  localparam logic [3:0] OP_ADD  = 4'd5;
  localparam logic [3:0] OP_SUB  = 4'd6;
  localparam logic [3:0] OP_MOV  = 4'd7;
  localparam logic [3:0] OP_DIV  = 4'd8;
  localparam logic [3:0] OP_TST  = 4'd9;

  // run conditions
  localparam logic [1:0] C_ALL = 2'd0;
  localparam logic [1:0] C_RST = 2'd1;
  localparam logic [1:0] C_UPD = 2'd2;

  // scratch file map
  localparam logic [RF_AW-1:0] A_X0 = 5'd0;
  localparam logic [RF_AW-1:0] A_X1 = 5'd1;
  localparam logic [RF_AW-1:0] A_X2 = 5'd2;
  localparam logic [RF_AW-1:0] A_P0 = 5'd3;
  localparam logic [RF_AW-1:0] A_P1 = 5'd4;
  localparam logic [RF_AW-1:0] A_P2 = 5'd5;
  localparam logic [RF_AW-1:0] A_P3 = 5'd6;
  localparam logic [RF_AW-1:0] A_P4 = 5'd7;
  localparam logic [RF_AW-1:0] A_P5 = 5'd8;
  localparam logic [RF_AW-1:0] A_P6 = 5'd9;
  localparam logic [RF_AW-1:0] A_P7 = 5'd10;
  localparam logic [RF_AW-1:0] A_P8 = 5'd11;
  localparam logic [RF_AW-1:0] A_M0 = 5'd12;
  localparam logic [RF_AW-1:0] A_M1 = 5'd13;
  localparam logic [RF_AW-1:0] A_M2 = 5'd14;
  localparam logic [RF_AW-1:0] A_M3 = 5'd15;
  localparam logic [RF_AW-1:0] A_M4 = 5'd16;
  localparam logic [RF_AW-1:0] A_M5 = 5'd17;
  localparam logic [RF_AW-1:0] A_DT = 5'd18;
  localparam logic [RF_AW-1:0] A_HH = 5'd19;
  localparam logic [RF_AW-1:0] A_QN = 5'd20;
  localparam logic [RF_AW-1:0] A_RN = 5'd21;
  localparam logic [RF_AW-1:0] A_ZZ = 5'd22;
  localparam logic [RF_AW-1:0] A_SS = 5'd23;
  localparam logic [RF_AW-1:0] A_YY = 5'd24;
  localparam logic [RF_AW-1:0] A_K0 = 5'd25;
  localparam logic [RF_AW-1:0] A_K1 = 5'd26;
  localparam logic [RF_AW-1:0] A_K2 = 5'd27;
  localparam logic [RF_AW-1:0] A_T0 = 5'd28;
  localparam logic [RF_AW-1:0] A_NONE = 5'd31;

  typedef struct packed {
    logic [1:0]       cond;
    logic [3:0]       op;
    logic [RF_AW-1:0] dst;
    logic [RF_AW-1:0] a;
    logic [RF_AW-1:0] b;
  } uop_t;

  typedef struct packed {
    logic zload;
    logic rd;
    logic ex;
    logic div_start;
    logic wr;
    logic boot;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic s_zero;
  } status_t;

  typedef struct packed {
    logic                        sat;
    logic signed [WORD_BITS-1:0] val;
  } clip_t;

  localparam logic signed [EXT_BITS-1:0] W_MAX =
    {{(EXT_BITS - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
  localparam logic signed [EXT_BITS-1:0] W_MIN = -W_MAX - 1;

  // clip a wide signed value to the word range
  function automatic clip_t clip_w(input logic signed [EXT_BITS-1:0] v);
    clip_t r;
    r.sat = 1'b0;
    r.val = v[WORD_BITS-1:0];
    if (v > W_MAX) begin
      r.sat = 1'b1;
      r.val = W_MAX[WORD_BITS-1:0];
    end else if (v < W_MIN) begin
      r.sat = 1'b1;
      r.val = W_MIN[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic uop_t mk(input logic [1:0] c, input logic [3:0] o,
                              input logic [RF_AW-1:0] d, input logic [RF_AW-1:0] a,
                              input logic [RF_AW-1:0] b);
    uop_t u;
    u.cond = c;
    u.op   = o;
    u.dst  = d;
    u.a    = a;
    u.b    = b;
    return u;
  endfunction

  localparam uop_t NOP_UOP = '{cond: C_ALL, op: OP_TST, dst: A_NONE, a: A_NONE, b: A_NONE};

  // one filter step: restart, predict, covariance propagation, correction
  localparam uop_t PROG [NOPS] = '{
    // restart: clear estimates, diagonal covariance from init registers
    mk(C_RST, OP_CLR, A_X0, A_NONE, A_NONE),
    mk(C_RST, OP_CLR, A_X1, A_NONE, A_NONE),
    mk(C_RST, OP_CLR, A_X2, A_NONE, A_NONE),
    mk(C_RST, OP_CLR, A_P1, A_NONE, A_NONE),
    mk(C_RST, OP_CLR, A_P2, A_NONE, A_NONE),
    mk(C_RST, OP_CLR, A_P3, A_NONE, A_NONE),
    mk(C_RST, OP_CLR, A_P5, A_NONE, A_NONE),
    mk(C_RST, OP_CLR, A_P6, A_NONE, A_NONE),
    mk(C_RST, OP_CLR, A_P7, A_NONE, A_NONE),
    mk(C_RST, OP_LDC, A_P0, 5'(REG_INIT_POS), A_NONE),
    mk(C_RST, OP_LDC, A_P4, 5'(REG_INIT_VEL), A_NONE),
    mk(C_RST, OP_LDC, A_P8, 5'(REG_INIT_ACC), A_NONE),
    // operands
    mk(C_ALL, OP_LDZ, A_ZZ, A_NONE, A_NONE),
    mk(C_ALL, OP_LDC, A_DT, 5'(REG_TIME_STEP), A_NONE),
    mk(C_ALL, OP_LDC, A_QN, 5'(REG_PROC_NOISE), A_NONE),
    mk(C_ALL, OP_LDC, A_RN, 5'(REG_MEAS_NOISE), A_NONE),
    mk(C_ALL, OP_MULH, A_HH, A_DT, A_DT),
    // state predict
    mk(C_ALL, OP_MUL, A_T0, A_DT, A_X1),
    mk(C_ALL, OP_ADD, A_X0, A_X0, A_T0),
    mk(C_ALL, OP_MUL, A_T0, A_HH, A_X2),
    mk(C_ALL, OP_ADD, A_X0, A_X0, A_T0),
    mk(C_ALL, OP_MUL, A_T0, A_DT, A_X2),
    mk(C_ALL, OP_ADD, A_X1, A_X1, A_T0),
    // m = a * p, column 0
    mk(C_ALL, OP_MUL, A_T0, A_DT, A_P3),
    mk(C_ALL, OP_ADD, A_M0, A_P0, A_T0),
    mk(C_ALL, OP_MUL, A_T0, A_HH, A_P6),
    mk(C_ALL, OP_ADD, A_M0, A_M0, A_T0),
    mk(C_ALL, OP_MUL, A_T0, A_DT, A_P6),
    mk(C_ALL, OP_ADD, A_M3, A_P3, A_T0),
    // column 1
    mk(C_ALL, OP_MUL, A_T0, A_DT, A_P4),
    mk(C_ALL, OP_ADD, A_M1, A_P1, A_T0),
    mk(C_ALL, OP_MUL, A_T0, A_HH, A_P7),
    mk(C_ALL, OP_ADD, A_M1, A_M1, A_T0),
    mk(C_ALL, OP_MUL, A_T0, A_DT, A_P7),
    mk(C_ALL, OP_ADD, A_M4, A_P4, A_T0),
    // column 2
    mk(C_ALL, OP_MUL, A_T0, A_DT, A_P5),
    mk(C_ALL, OP_ADD, A_M2, A_P2, A_T0),
    mk(C_ALL, OP_MUL, A_T0, A_HH, A_P8),
    mk(C_ALL, OP_ADD, A_M2, A_M2, A_T0),
    mk(C_ALL, OP_MUL, A_T0, A_DT, A_P8),
    mk(C_ALL, OP_ADD, A_M5, A_P5, A_T0),
    // p = m * a^t, upper triangle
    mk(C_ALL, OP_MUL, A_T0, A_DT, A_M1),
    mk(C_ALL, OP_ADD, A_P0, A_M0, A_T0),
    mk(C_ALL, OP_MUL, A_T0, A_HH, A_M2),
    mk(C_ALL, OP_ADD, A_P0, A_P0, A_T0),
    mk(C_ALL, OP_MUL, A_T0, A_DT, A_M2),
    mk(C_ALL, OP_ADD, A_P1, A_M1, A_T0),
    mk(C_ALL, OP_MOV, A_P2, A_M2, A_NONE),
    mk(C_ALL, OP_MUL, A_T0, A_DT, A_M5),
    mk(C_ALL, OP_ADD, A_P4, A_M4, A_T0),
    mk(C_ALL, OP_MOV, A_P5, A_M5, A_NONE),
    mk(C_ALL, OP_ADD, A_P8, A_P8, A_QN),
    mk(C_ALL, OP_MOV, A_P3, A_P1, A_NONE),
    mk(C_ALL, OP_MOV, A_P6, A_P2, A_NONE),
    mk(C_ALL, OP_MOV, A_P7, A_P5, A_NONE),
    // innovation variance and zero check
    mk(C_ALL, OP_ADD, A_SS, A_P8, A_RN),
    mk(C_ALL, OP_TST, A_NONE, A_SS, A_NONE),
    // gains
    mk(C_UPD, OP_DIV, A_K0, A_P2, A_SS),
    mk(C_UPD, OP_DIV, A_K1, A_P5, A_SS),
    mk(C_UPD, OP_DIV, A_K2, A_P8, A_SS),
    mk(C_UPD, OP_SUB, A_YY, A_ZZ, A_X2),
    // state correction
    mk(C_UPD, OP_MUL, A_T0, A_K0, A_YY),
    mk(C_UPD, OP_ADD, A_X0, A_X0, A_T0),
    mk(C_UPD, OP_MUL, A_T0, A_K1, A_YY),
    mk(C_UPD, OP_ADD, A_X1, A_X1, A_T0),
    mk(C_UPD, OP_MUL, A_T0, A_K2, A_YY),
    mk(C_UPD, OP_ADD, A_X2, A_X2, A_T0),
    // covariance correction, in place, last row read before written
    mk(C_UPD, OP_MUL, A_T0, A_K0, A_P6),
    mk(C_UPD, OP_SUB, A_P0, A_P0, A_T0),
    mk(C_UPD, OP_MUL, A_T0, A_K0, A_P7),
    mk(C_UPD, OP_SUB, A_P1, A_P1, A_T0),
    mk(C_UPD, OP_MUL, A_T0, A_K0, A_P8),
    mk(C_UPD, OP_SUB, A_P2, A_P2, A_T0),
    mk(C_UPD, OP_MUL, A_T0, A_K1, A_P7),
    mk(C_UPD, OP_SUB, A_P4, A_P4, A_T0),
    mk(C_UPD, OP_MUL, A_T0, A_K1, A_P8),
    mk(C_UPD, OP_SUB, A_P5, A_P5, A_T0),
    mk(C_UPD, OP_MUL, A_T0, A_K2, A_P8),
    mk(C_UPD, OP_SUB, A_P8, A_P8, A_T0),
    mk(C_UPD, OP_MOV, A_P3, A_P1, A_NONE),
    mk(C_UPD, OP_MOV, A_P6, A_P2, A_NONE),
    mk(C_UPD, OP_MOV, A_P7, A_P5, A_NONE)
  };

endpackage

// ===== rtl/kfca_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module kfca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/kfca_div.sv =====
// restoring divider, one quotient bit per cycle: (|n| << frac) / |d| with sign
// depends on kfca_pkg
`timescale 1ns / 1ps
module kfca_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [kfca_pkg::WORD_BITS-1:0] num,
  input  logic signed [kfca_pkg::WORD_BITS-1:0] den,
  output logic                                 done_r,
  output logic signed [kfca_pkg::EXT_BITS-1:0]  quot
);
  import kfca_pkg::*;

  localparam int CNT_W = $clog2(DVD_BITS + 1);

  logic [WORD_BITS-1:0] md_r, md_nxt;
  logic [WORD_BITS-1:0] rem_r, rem_nxt;
  logic [DVD_BITS-1:0]  dvd_r, dvd_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic                 done_nxt;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS-1:0] mn;
  logic signed [EXT_BITS-1:0] qw;

  assign mn    = num[WORD_BITS-1] ? WORD_BITS'(-num) : WORD_BITS'(num);
  assign trial = {rem_r, dvd_r[DVD_BITS-1]};
  assign qw    = EXT_BITS'(dvd_r);
  assign quot  = neg_r ? -qw : qw;

  // iteration
  always_comb begin
    md_nxt   = md_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (start) begin
      md_nxt  = den[WORD_BITS-1] ? WORD_BITS'(-den) : WORD_BITS'(den);
      rem_nxt = '0;
      dvd_nxt = {mn, {FRAC_BITS{1'b0}}};
      cnt_nxt = CNT_W'(DVD_BITS);
      neg_nxt = num[WORD_BITS-1] ^ den[WORD_BITS-1];
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, md_r}) begin
        rem_nxt = WORD_BITS'(trial - {1'b0, md_r});
        dvd_nxt = {dvd_r[DVD_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[WORD_BITS-1:0];
        dvd_nxt = {dvd_r[DVD_BITS-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    md_r  <= md_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    neg_r <= neg_nxt;
  end

endmodule

// ===== rtl/kfca_datapath.sv =====
// datapath: scratch file in two ram copies, shared multiplier, adder, divider
// depends on kfca_pkg, kfca_ram, kfca_div
`timescale 1ns / 1ps
module kfca_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  kfca_pkg::cmd_t                        cmd,
  input  kfca_pkg::cfg_arr_t                    cfg,
  input  logic signed [kfca_pkg::WORD_BITS-1:0] in_z,
  output kfca_pkg::status_t                     status,
  output kfca_pkg::out_t                        result
);
  import kfca_pkg::*;

  logic [WORD_BITS-1:0]         ra, rb;
  logic                         we;
  logic [WORD_BITS-1:0]         wdata;
  logic [WORD_BITS-1:0]         mag_a, mag_b;
  logic [2*WORD_BITS-1:0]       prod_r;
  logic                         neg_r;
  logic signed [WORD_BITS+1:0]  sum_r;
  logic signed [WORD_BITS-1:0]  a_r;
  logic signed [WORD_BITS-1:0]  z_r;
  logic signed [WORD_BITS-1:0]  est_r [3];
  logic                         sat_r, sat_nxt;
  logic                         szero_r, szero_nxt;
  logic                         div_done;
  logic signed [EXT_BITS-1:0]   div_q;
  logic [2*WORD_BITS:0]         rnd;
  logic signed [EXT_BITS-1:0]   mq, mres;
  clip_t                        cl;
  logic                         use_clip;
  logic [REG_W-1:0]             cfg_val;

  // two copies give two read ports
  kfca_ram #(.WIDTH(WORD_BITS), .DEPTH(RF_DEPTH)) u_ram_a (
    .clk(clk), .we(we), .waddr(cmd.uop.dst), .wdata(wdata),
    .re(cmd.rd), .raddr(cmd.uop.a), .rdata_r(ra)
  );
  kfca_ram #(.WIDTH(WORD_BITS), .DEPTH(RF_DEPTH)) u_ram_b (
    .clk(clk), .we(we), .waddr(cmd.uop.dst), .wdata(wdata),
    .re(cmd.rd), .raddr(cmd.uop.b), .rdata_r(rb)
  );

  kfca_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(signed'(ra)), .den(signed'(rb)), .done_r(div_done), .quot(div_q)
  );

  // execute stage: magnitude product and sum
  assign mag_a = ra[WORD_BITS-1] ? WORD_BITS'(-ra) : ra;
  assign mag_b = rb[WORD_BITS-1] ? WORD_BITS'(-rb) : rb;

  always_ff @(posedge clk) begin
    if (cmd.ex) begin
      prod_r <= mag_a * mag_b;
      neg_r  <= ra[WORD_BITS-1] ^ rb[WORD_BITS-1];
      a_r    <= signed'(ra);
      if (cmd.uop.op == OP_SUB) begin
        sum_r <= (WORD_BITS+2)'(signed'(ra)) - (WORD_BITS+2)'(signed'(rb));
      end else begin
        sum_r <= (WORD_BITS+2)'(signed'(ra)) + (WORD_BITS+2)'(signed'(rb));
      end
    end
    if (cmd.zload) begin
      z_r <= in_z;
    end
  end

  // round to nearest, ties away from zero, then sign
  always_comb begin
    rnd = {1'b0, prod_r};
    if (cmd.uop.op == OP_MULH) begin
      rnd = rnd + ((2*WORD_BITS+1)'(1) << FRAC_BITS);
      mq  = EXT_BITS'(rnd >> (FRAC_BITS + 1));
    end else begin
      rnd = rnd + ((2*WORD_BITS+1)'(1) << (FRAC_BITS - 1));
      mq  = EXT_BITS'(rnd >> FRAC_BITS);
    end
    mres = neg_r ? -mq : mq;
  end

  // write stage result select, first step after reset uses the reset covariance
  always_comb begin
    cfg_val  = '0;
    case (cmd.uop.a[2:0])
      REG_TIME_STEP:  cfg_val = cfg[0];
      REG_PROC_NOISE: cfg_val = cfg[1];
      REG_MEAS_NOISE: cfg_val = cfg[2];
      REG_INIT_POS:   cfg_val = cmd.boot ? RST_INIT_POS : cfg[3];
      REG_INIT_VEL:   cfg_val = cmd.boot ? RST_INIT_VEL : cfg[4];
      REG_INIT_ACC:   cfg_val = cmd.boot ? RST_INIT_ACC : cfg[5];
      default:        cfg_val = '0;
    endcase
    use_clip = 1'b0;
    cl       = clip_w(EXT_BITS'(sum_r));
    wdata    = '0;
    case (cmd.uop.op)
      OP_CLR:  wdata = '0;
      OP_LDC:  wdata = WORD_BITS'(cfg_val);
      OP_LDZ:  wdata = z_r;
      OP_MOV:  wdata = a_r;
      OP_MUL, OP_MULH: begin
        cl       = clip_w(mres);
        use_clip = 1'b1;
        wdata    = cl.val;
      end
      OP_ADD, OP_SUB: begin
        use_clip = 1'b1;
        wdata    = cl.val;
      end
      OP_DIV: begin
        cl       = clip_w(div_q);
        use_clip = 1'b1;
        wdata    = cl.val;
      end
      default: wdata = '0;
    endcase
    we = cmd.wr && (cmd.uop.op != OP_TST);
  end

  // saturation and zero-divisor flags
  always_comb begin
    sat_nxt   = sat_r;
    szero_nxt = szero_r;
    if (cmd.zload) begin
      sat_nxt = 1'b0;
    end else if (cmd.wr) begin
      if (use_clip && cl.sat) begin
        sat_nxt = 1'b1;
      end
      if (cmd.uop.op == OP_TST) begin
        szero_nxt = (a_r == '0);
        if (a_r == '0) begin
          sat_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r   <= 1'b0;
      szero_r <= 1'b0;
    end else begin
      sat_r   <= sat_nxt;
      szero_r <= szero_nxt;
    end
  end

  // shadow copies of the estimates for the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r[0] <= '0;
      est_r[1] <= '0;
      est_r[2] <= '0;
    end else if (we) begin
      case (cmd.uop.dst)
        A_X0:    est_r[0] <= signed'(wdata);
        A_X1:    est_r[1] <= signed'(wdata);
        A_X2:    est_r[2] <= signed'(wdata);
        default: ;
      endcase
    end
  end

  assign status.div_done    = div_done;
  assign status.s_zero      = szero_r;
  assign result.est_position = est_r[0];
  assign result.est_velocity = est_r[1];
  assign result.est_accel    = est_r[2];
  assign result.saturated    = sat_r;

endmodule

// ===== rtl/kfca_ctrl.sv =====
// sequencer: walks the operation program and drives datapath commands
// depends on kfca_pkg and the assertion header
`timescale 1ns / 1ps
`include "kalman_filter_const_accel_core_assert.svh"
module kfca_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_restart,
  input  logic              out_free,
  input  kfca_pkg::status_t status,
  output kfca_pkg::cmd_t    cmd,
  output logic              in_stall,
  output logic              out_load
);
  import kfca_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [PC_BITS-1:0] pc_r, pc_nxt;
  logic               rst_flag_r, rst_flag_nxt;
  logic               boot_r, boot_nxt;
  uop_t               uop;
  logic               skip;

  assign uop  = (pc_r < PC_BITS'(NOPS)) ? PROG[pc_r] : NOP_UOP;
  assign skip = ((uop.cond == C_RST) && !rst_flag_r) ||
                ((uop.cond == C_UPD) && status.s_zero);
  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    rst_flag_nxt  = rst_flag_r;
    boot_nxt      = boot_r;
    out_load      = 1'b0;
    cmd           = '0;
    cmd.uop       = uop;
    cmd.boot      = boot_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.zload    = 1'b1;
          pc_nxt       = '0;
          // first step after reset loads the reset covariance itself
          rst_flag_nxt = in_restart || boot_r;
          boot_nxt     = boot_r && !in_restart;
          state_nxt    = S_FETCH;
        end
      end
      S_FETCH: begin
        if (pc_r == PC_BITS'(NOPS)) begin
          state_nxt = S_OUT;
        end else if (skip) begin
          pc_nxt = pc_r + 1'b1;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.ex = 1'b1;
        if (uop.op == OP_DIV) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        cmd.wr    = 1'b1;
        pc_nxt    = pc_r + 1'b1;
        state_nxt = S_FETCH;
      end
      S_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          boot_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pc_r       <= '0;
      rst_flag_r <= 1'b0;
      boot_r     <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      pc_r       <= pc_nxt;
      rst_flag_r <= rst_flag_nxt;
      boot_r     <= boot_nxt;
    end
  end

  `KFCA_ASSERT_NOW(a_wr_in_prog, state_r == S_WR, pc_r < PC_BITS'(NOPS), "write past program end")
  `KFCA_ASSERT_NOW(a_div_op, state_r == S_DIV, uop.op == OP_DIV, "divide wait without divide")
  `KFCA_ASSERT_NEXT(a_out_leave, (state_r == S_OUT) && out_free, state_r == S_IDLE, "result not issued")

endmodule

// ===== rtl/kalman_filter_const_accel_core.sv =====
// Three-state constant-acceleration Kalman filter, signed Q16.16. One input
// beat (measured acceleration, restart) gives one result beat (position,
// velocity, acceleration estimates and a saturation flag). A sequencer runs a
// fixed program of 82 operations over one shared multiplier, adder and a
// one-bit-per-cycle divider, working out of a 32-entry scratch ram: each
// executed operation passes through the fetch, execute and write states,
// a skipped one only through fetch, and each of the three gain divisions
// waits in the divide state between execute and write. A restart step also
// runs the restart operations, and a step whose divisor is zero skips the
// correction. The first step after reset starts from zero estimates and the
// reset-value covariance, loaded as part of that step. The next input beat
// is taken once the previous result sits in the output register.
// depends on kfca_pkg, kfca_ctrl, kfca_datapath
`timescale 1ns / 1ps
module kalman_filter_const_accel_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  kfca_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output kfca_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [kfca_pkg::REG_W-1:0] cfg_data
);
  import kfca_pkg::*;

  cfg_arr_t cfg_r;
  cmd_t     cmd;
  status_t  status;
  out_t     result;
  out_t     out_data_r;
  logic     out_valid_r, out_valid_nxt;
  logic     out_load;
  logic     out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[0] <= RST_TIME_STEP;
      cfg_r[1] <= RST_PROC_NOISE;
      cfg_r[2] <= RST_MEAS_NOISE;
      cfg_r[3] <= RST_INIT_POS;
      cfg_r[4] <= RST_INIT_VEL;
      cfg_r[5] <= RST_INIT_ACC;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP:  cfg_r[0] <= cfg_data;
        REG_PROC_NOISE: cfg_r[1] <= cfg_data;
        REG_MEAS_NOISE: cfg_r[2] <= cfg_data;
        REG_INIT_POS:   cfg_r[3] <= cfg_data;
        REG_INIT_VEL:   cfg_r[4] <= cfg_data;
        REG_INIT_ACC:   cfg_r[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  kfca_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_restart(in_data.restart),
    .out_free(out_free), .status(status), .cmd(cmd), .in_stall(in_stall),
    .out_load(out_load)
  );

  kfca_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .cfg(cfg_r),
    .in_z(in_data.measured_accel), .status(status), .result(result)
  );

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/tb_kalman_filter_const_accel_core.sv =====
// self-checking bench for the constant-acceleration kalman filter core
// depends on kfca_pkg and kalman_filter_const_accel_core
`timescale 1ns / 1ps
module tb_kalman_filter_const_accel_core;
  import kfca_pkg::*;

  localparam longint WMAXL = 64'sd2147483647;
  localparam longint WMINL = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  kalman_filter_const_accel_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // filter state mirrored in the bench
  logic [REG_W-1:0] reg_copy [NREG];
  longint est [3];
  longint cov [9];
  bit sat_seen;

  in_t  sample_q [$];
  out_t estimate_q [$];
  int errors = 0;
  int results_seen = 0;
  bit quiet = 1'b0;
  int cycles = 0;

  function automatic longint clip_word(longint v);
    if (v > WMAXL) begin
      sat_seen = 1'b1;
      return WMAXL;
    end
    if (v < WMINL) begin
      sat_seen = 1'b1;
      return WMINL;
    end
    return v;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    return clip_word(a + b);
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    return clip_word(a - b);
  endfunction

  // product with round half away from zero on the magnitude
  function automatic longint mul_round(longint a, longint b, int sh);
    longint unsigned ma, mb, q;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    q = (ma * mb + (64'd1 << (sh - 1))) >> sh;
    return clip_word(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint mul_q(longint a, longint b);
    return mul_round(a, b, FRAC_BITS);
  endfunction

  // truncating fixed-point quotient
  function automatic longint gain_div(longint n, longint d);
    longint unsigned mn, md, q;
    bit neg;
    neg = (n < 0) != (d < 0);
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    q = (mn << FRAC_BITS) / md;
    return clip_word(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic out_t filter_step(in_t smp);
    longint z, dt, hh, s, y;
    longint m [9];
    longint old [9];
    longint k [3];
    out_t r;
    sat_seen = 1'b0;
    z = longint'(smp.measured_accel);
    if (smp.restart) begin
      for (int i = 0; i < 3; i++) est[i] = 0;
      for (int i = 0; i < 9; i++) cov[i] = 0;
      cov[0] = clip_word(longint'(reg_copy[REG_INIT_POS]));
      cov[4] = clip_word(longint'(reg_copy[REG_INIT_VEL]));
      cov[8] = clip_word(longint'(reg_copy[REG_INIT_ACC]));
    end
    dt = clip_word(longint'(reg_copy[REG_TIME_STEP]));
    hh = mul_round(dt, dt, FRAC_BITS + 1);
    // state predict
    est[0] = add_sat(add_sat(est[0], mul_q(dt, est[1])), mul_q(hh, est[2]));
    est[1] = add_sat(est[1], mul_q(dt, est[2]));
    // a * p
    for (int j = 0; j < 3; j++) begin
      m[j] = add_sat(add_sat(cov[j], mul_q(dt, cov[3 + j])), mul_q(hh, cov[6 + j]));
      m[3 + j] = add_sat(cov[3 + j], mul_q(dt, cov[6 + j]));
      m[6 + j] = cov[6 + j];
    end
    // (a * p) * a^t, upper triangle
    for (int i = 0; i < 3; i++) begin
      for (int j = i; j < 3; j++) begin
        if (j == 0)
          cov[3*i + j] = add_sat(add_sat(m[3*i], mul_q(dt, m[3*i + 1])),
                                 mul_q(hh, m[3*i + 2]));
        else if (j == 1)
          cov[3*i + j] = add_sat(m[3*i + 1], mul_q(dt, m[3*i + 2]));
        else
          cov[3*i + j] = m[3*i + 2];
      end
    end
    cov[8] = add_sat(cov[8], clip_word(longint'(reg_copy[REG_PROC_NOISE])));
    cov[3] = cov[1];
    cov[6] = cov[2];
    cov[7] = cov[5];
    // correction, skipped on a zero innovation variance
    s = add_sat(cov[8], clip_word(longint'(reg_copy[REG_MEAS_NOISE])));
    if (s == 0) begin
      sat_seen = 1'b1;
    end else begin
      old = cov;
      for (int i = 0; i < 3; i++) k[i] = gain_div(old[3*i + 2], s);
      y = sub_sat(z, est[2]);
      for (int i = 0; i < 3; i++) est[i] = add_sat(est[i], mul_q(k[i], y));
      for (int i = 0; i < 3; i++)
        for (int j = i; j < 3; j++)
          cov[3*i + j] = sub_sat(old[3*i + j], mul_q(k[i], old[6 + j]));
      cov[3] = cov[1];
      cov[6] = cov[2];
      cov[7] = cov[5];
    end
    r.est_position = est[0][31:0];
    r.est_velocity = est[1][31:0];
    r.est_accel    = est[2][31:0];
    r.saturated    = sat_seen;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 5);
    return $urandom_range(20, 150);
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[kalman_filter_const_accel_core] ERROR");
      $finish;
    end
  end

  // input driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) estimate_q.push_back(filter_step(in_data));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= sample_q.pop_front();
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  int stall_left = 0;
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (estimate_q.size() == 0) begin
          errors++;
          $display("%0t unexpected beat: got %p", $time, out_data);
        end else begin
          want = estimate_q.pop_front();
          if (want.est_position !== out_data.est_position)
            $display("%0t est_position: exp %0d got %0d", $time,
                     want.est_position, out_data.est_position);
          if (want.est_velocity !== out_data.est_velocity)
            $display("%0t est_velocity: exp %0d got %0d", $time,
                     want.est_velocity, out_data.est_velocity);
          if (want.est_accel !== out_data.est_accel)
            $display("%0t est_accel: exp %0d got %0d", $time,
                     want.est_accel, out_data.est_accel);
          if (want.saturated !== out_data.saturated)
            $display("%0t saturated: exp %0b got %0b", $time,
                     want.saturated, out_data.saturated);
          if (want !== out_data) errors++;
        end
        // one long hold-off so the core backs up into its input
        if (results_seen == 200) stall_left = 3000;
      end
      if (stall_left == 0) begin
        stall_left = pick_gap();
        if (stall_left > 0 && $urandom_range(0, 3) != 0) stall_left = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    reg_copy[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_regs(logic [REG_W-1:0] dt, logic [REG_W-1:0] q,
                           logic [REG_W-1:0] r, logic [REG_W-1:0] p0,
                           logic [REG_W-1:0] p1, logic [REG_W-1:0] p2);
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_PROC_NOISE, q);
    write_reg(REG_MEAS_NOISE, r);
    write_reg(REG_INIT_POS, p0);
    write_reg(REG_INIT_VEL, p1);
    write_reg(REG_INIT_ACC, p2);
  endtask

  // sender stops until the core has returned every estimate
  task automatic drain();
    while (sample_q.size() > 0 || in_valid || estimate_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_sample(logic signed [31:0] z, logic rs);
    in_t smp;
    smp.measured_accel = z;
    smp.restart = rs;
    sample_q.push_back(smp);
  endtask

  function automatic logic [REG_W-1:0] rand_reg(int unsigned hi);
    if ($urandom_range(0, 9) == 0) return REG_W'($urandom());
    return REG_W'($urandom_range(0, hi));
  endfunction

  initial begin
    logic signed [31:0] z;
    reg_copy[REG_TIME_STEP]  = RST_TIME_STEP;
    reg_copy[REG_PROC_NOISE] = RST_PROC_NOISE;
    reg_copy[REG_MEAS_NOISE] = RST_MEAS_NOISE;
    reg_copy[REG_INIT_POS]   = RST_INIT_POS;
    reg_copy[REG_INIT_VEL]   = RST_INIT_VEL;
    reg_copy[REG_INIT_ACC]   = RST_INIT_ACC;
    for (int i = 0; i < 3; i++) est[i] = 0;
    for (int i = 0; i < 9; i++) cov[i] = 0;
    cov[0] = RST_INIT_POS;
    cov[4] = RST_INIT_VEL;
    cov[8] = RST_INIT_ACC;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, field extremes, restart mid-run
    push_sample(32'sd0, 1'b0);
    push_sample(32'sh7fffffff, 1'b0);
    push_sample(32'sh80000000, 1'b0);
    push_sample(-32'sd1, 1'b0);
    push_sample(32'sd65536, 1'b1);
    push_sample(32'sd1, 1'b0);
    push_sample(-32'sd65536, 1'b0);
    push_sample(32'sh7fffffff, 1'b1);
    drain();

    // zero innovation variance: update skipped
    load_regs(31'd6554, 31'd0, 31'd0, 31'd65536, 31'd65536, 31'd0);
    push_sample(32'sd131072, 1'b1);
    push_sample(-32'sd5000, 1'b0);
    push_sample(32'sh80000000, 1'b0);
    drain();

    // largest settings, clipping everywhere
    load_regs('1, '1, '1, '1, '1, '1);
    push_sample(32'sh7fffffff, 1'b1);
    push_sample(32'sh80000000, 1'b0);
    push_sample(32'sh7fffffff, 1'b0);
    push_sample(32'sd12345, 1'b1);
    drain();

    // zero time step, tiny measurement noise
    load_regs(31'd0, 31'd0, 31'd1, 31'd0, 31'd0, 31'd1);
    push_sample(32'sd100000, 1'b1);
    push_sample(-32'sd100000, 1'b0);
    push_sample(32'sh7fffffff, 1'b0);
    drain();

    // random phases, each started by a restart
    for (int ph = 0; ph < 6; ph++) begin
      load_regs(rand_reg(32768), rand_reg(65536), rand_reg(65536),
                rand_reg(1 << 20), rand_reg(1 << 20), rand_reg(1 << 21));
      quiet = (ph == 2);
      for (int n = 0; n < 172; n++) begin
        if ($urandom_range(0, 4) == 0) z = $urandom();
        else z = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        push_sample(z, n == 0 || $urandom_range(0, 29) == 0);
      end
      drain();
    end
    quiet = 1'b0;

    repeat (500) @(posedge clk);
    if (errors == 0 && estimate_q.size() == 0) begin
      $display("[kalman_filter_const_accel_core] OK");
    end else begin
      $display("[kalman_filter_const_accel_core] ERROR");
    end
    $finish;
  end

endmodule
